FILE: hdl/fcps_pkg.sv
// Shared types and constants for the fuel-cell plant supervisor.
// Holds the payload, configuration and supervisor-state structs.
// No dependencies.
`timescale 1ns / 1ps

package fcps_pkg;

  // Opcodes of an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // Fault codes
  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_STOP     = 2'd1;
  localparam logic [1:0] FAULT_OVERHEAT = 2'd2;
  localparam logic [1:0] FAULT_LEAK     = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAT_BELOW     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WARM_ABOVE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOT_FROM       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COOL_ABOVE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OVERHEAT_TEMP  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OVERHEAT_TICKS = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LEAK_LIMIT     = 3'd6;

  // Relay bit positions
  localparam int unsigned RELAY_W = 9;
  localparam int unsigned B_PUMP   = 0;
  localparam int unsigned B_SEA    = 1;
  localparam int unsigned B_HEATER = 2;
  localparam int unsigned B_HBYP   = 3;
  localparam int unsigned B_SBYP   = 4;
  localparam int unsigned B_AIR    = 5;
  localparam int unsigned B_OXP    = 6;
  localparam int unsigned B_H2F    = 7;
  localparam int unsigned B_H2P    = 8;

  // Purge timing in milliseconds
  localparam logic [31:0] OX_OPEN_MS  = 32'd180000;
  localparam logic [31:0] OX_CLOSE_MS = 32'd190000;
  localparam logic [31:0] HY_OPEN_MS  = 32'd60000;
  localparam logic [31:0] HY_CLOSE_MS = 32'd63000;

  localparam logic [6:0] HOT_MAX = 7'd127;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] temperature_q;
    logic [9:0]  hydrogen_feed_level;
    logic [9:0]  hydrogen_exhaust_level;
    logic [15:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    logic       main_pump;
    logic       sea_pump;
    logic       heater_relay;
    logic       heater_bypass_valve;
    logic       sea_bypass_valve;
    logic       air_compressor;
    logic       oxygen_purge;
    logic       hydrogen_feed;
    logic       hydrogen_purge;
    logic       running;
    logic [1:0] fault_code;
    logic       valve_move;
  } result_t;

  typedef struct packed {
    logic [11:0] heat_below;
    logic [11:0] warm_above;
    logic [11:0] hot_from;
    logic [11:0] cool_above;
    logic [11:0] overheat_temp;
    logic [6:0]  overheat_ticks;
    logic [9:0]  leak_limit;
  } cfg_t;

  // Purge clocks are kept as ages (clock minus mark), which is all the
  // purge logic ever looks at.
  typedef struct packed {
    logic               run_flag;
    logic [6:0]         hot_count;
    logic [31:0]        ox_age;
    logic [31:0]        hy_age;
    logic               ox_purging;
    logic               hy_purging;
    logic [RELAY_W-1:0] relays;
    logic [1:0]         last_fault;
  } sup_state_t;

endpackage

FILE: hdl/fuel_cell_plant_supervisor_core.sv
// Top level of the fuel-cell plant supervisor: input register, state, result register.
// Depends on fcps_pkg, fcps_cfg_regs and fcps_step.
`timescale 1ns / 1ps

// Fuel-cell plant supervisor. Each input transfer carries one opcode (tick,
// start, stop) with a stack temperature, two hydrogen readings and the
// elapsed milliseconds; each one yields exactly one result transfer with the
// nine relay/valve states, the running flag, the held fault code and a
// valve-power pulse flag. Items pass through the input register, then
// through the step logic into the result register. A new item is taken
// every cycle unless the input side stalls; the supervisor state is
// updated as the item leaves the input register, so the next item sees it.
// The input side stalls only when both the input register and the result
// register are full and the result is stalled. Configuration registers are
// written through cfg_we/cfg_index/cfg_wdata and must only change while no
// item is in flight; writes to an index beyond the register list are dropped.
// The purge clocks are kept as ages since the last purge mark.
module fuel_cell_plant_supervisor_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fcps_pkg::item_t                   in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fcps_pkg::result_t                 out_data,
  input  logic                              cfg_we,
  input  logic [fcps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fcps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  fcps_pkg::cfg_t       cfg;
  fcps_pkg::sup_state_t st;
  fcps_pkg::sup_state_t st_next;
  fcps_pkg::item_t      item;
  fcps_pkg::result_t    res;
  logic                 item_valid;
  logic                 in_take;
  logic                 advance;

  fcps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fcps_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res)
  );

  // Advance the held item into the result register unless a result is
  // already waiting and the far side is stalling.
  assign advance  = item_valid && !(out_valid && out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= in_data;
    end
  end

  // Supervisor state: commit when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register: hold while stalled, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_halted_relays_off: assert property (@(posedge clk) disable iff (rst)
    !st.run_flag |-> (st.relays == '0))
    else $error("relays on while halted");

  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    (st.last_fault != fcps_pkg::FAULT_NONE) |-> !st.run_flag)
    else $error("fault recorded while running");

  a_purge_flags: assert property (@(posedge clk) disable iff (rst)
    (st.ox_purging == st.relays[fcps_pkg::B_OXP]) &&
    (st.hy_purging == st.relays[fcps_pkg::B_H2P]))
    else $error("purge flag and valve disagree");

  a_move_running: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.valve_move) |-> out_data.running)
    else $error("valve pulse without running");
`endif

endmodule

FILE: hdl/fcps_cfg_regs.sv
// Configuration register file of the fuel-cell plant supervisor.
// Depends on fcps_pkg.
`timescale 1ns / 1ps

module fcps_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fcps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fcps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output fcps_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heat_below     <= 12'd280;
      cfg.warm_above     <= 12'd288;
      cfg.hot_from       <= 12'd320;
      cfg.cool_above     <= 12'd328;
      cfg.overheat_temp  <= 12'd360;
      cfg.overheat_ticks <= 7'd100;
      cfg.leak_limit     <= 10'd300;
    end else if (cfg_we) begin
      case (cfg_index)
        fcps_pkg::REG_HEAT_BELOW:     cfg.heat_below     <= cfg_wdata;
        fcps_pkg::REG_WARM_ABOVE:     cfg.warm_above     <= cfg_wdata;
        fcps_pkg::REG_HOT_FROM:       cfg.hot_from       <= cfg_wdata;
        fcps_pkg::REG_COOL_ABOVE:     cfg.cool_above     <= cfg_wdata;
        fcps_pkg::REG_OVERHEAT_TEMP:  cfg.overheat_temp  <= cfg_wdata;
        fcps_pkg::REG_OVERHEAT_TICKS: cfg.overheat_ticks <= cfg_wdata[6:0];
        fcps_pkg::REG_LEAK_LIMIT:     cfg.leak_limit     <= cfg_wdata[9:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

endmodule

FILE: hdl/fcps_step.sv
// Single-pass supervisor step: next state and result for one item.
// Purely combinational. Depends on fcps_pkg.
`timescale 1ns / 1ps

module fcps_step (
  input  fcps_pkg::cfg_t       cfg,
  input  fcps_pkg::sup_state_t st,
  input  fcps_pkg::item_t      item,
  output fcps_pkg::sup_state_t st_next,
  output fcps_pkg::result_t    res
);

  logic [31:0] ox_age_adv;
  logic [31:0] hy_age_adv;
  logic [11:0] t;
  logic        moved;
  logic        move_out;
  logic        overheat;
  logic        leak;
  logic [6:0]  hot_band;
  logic [fcps_pkg::RELAY_W-1:0] relays_band;

  assign t          = item.temperature_q;
  assign ox_age_adv = st.ox_age + {16'd0, item.elapsed_ms};
  assign hy_age_adv = st.hy_age + {16'd0, item.elapsed_ms};

  // Coolant band selection
  always_comb begin
    relays_band = st.relays;
    hot_band    = st.hot_count;
    moved       = 1'b0;
    if (t < cfg.heat_below) begin
      relays_band[fcps_pkg::B_HEATER] = 1'b1;
      relays_band[fcps_pkg::B_HBYP]   = 1'b0;
      relays_band[fcps_pkg::B_SBYP]   = 1'b0;
      relays_band[fcps_pkg::B_PUMP]   = 1'b1;
      relays_band[fcps_pkg::B_SEA]    = 1'b0;
      moved    = 1'b1;
      hot_band = '0;
    end else if (t < cfg.hot_from) begin
      if (t > cfg.warm_above) begin
        relays_band[fcps_pkg::B_HEATER] = 1'b0;
        relays_band[fcps_pkg::B_HBYP]   = 1'b1;
        relays_band[fcps_pkg::B_SBYP]   = 1'b0;
        relays_band[fcps_pkg::B_PUMP]   = 1'b1;
        relays_band[fcps_pkg::B_SEA]    = 1'b0;
        moved = 1'b1;
      end
      relays_band[fcps_pkg::B_H2F] = 1'b1;
      relays_band[fcps_pkg::B_AIR] = 1'b1;
      hot_band = '0;
    end else if (t > cfg.cool_above) begin
      relays_band[fcps_pkg::B_HEATER] = 1'b0;
      relays_band[fcps_pkg::B_HBYP]   = 1'b1;
      relays_band[fcps_pkg::B_SBYP]   = 1'b0;
      relays_band[fcps_pkg::B_PUMP]   = 1'b1;
      relays_band[fcps_pkg::B_SEA]    = 1'b1;
      moved = 1'b1;
      if (st.hot_count != fcps_pkg::HOT_MAX) begin
        hot_band = st.hot_count + 7'd1;
      end
    end
  end

  assign overheat = (hot_band >= cfg.overheat_ticks) && (t > cfg.overheat_temp);
  assign leak     = (item.hydrogen_feed_level > cfg.leak_limit) ||
                    (item.hydrogen_exhaust_level > cfg.leak_limit);

  always_comb begin
    st_next  = st;
    move_out = 1'b0;
    case (item.opcode)
      fcps_pkg::OP_START: begin
        if (!st.run_flag) begin
          st_next.run_flag   = 1'b1;
          st_next.hot_count  = '0;
          st_next.ox_age     = '0;
          st_next.hy_age     = '0;
          st_next.ox_purging = 1'b0;
          st_next.hy_purging = 1'b0;
          st_next.relays     = '0;
          st_next.last_fault = fcps_pkg::FAULT_NONE;
        end
      end
      fcps_pkg::OP_STOP: begin
        if (st.run_flag) begin
          st_next.run_flag   = 1'b0;
          st_next.ox_purging = 1'b0;
          st_next.hy_purging = 1'b0;
          st_next.relays     = '0;
          st_next.last_fault = fcps_pkg::FAULT_STOP;
        end
      end
      fcps_pkg::OP_TICK: begin
        if (st.run_flag) begin
          st_next.ox_age    = ox_age_adv;
          st_next.hy_age    = hy_age_adv;
          st_next.hot_count = hot_band;
          st_next.relays    = relays_band;
          if (overheat || leak) begin
            st_next.run_flag   = 1'b0;
            st_next.ox_purging = 1'b0;
            st_next.hy_purging = 1'b0;
            st_next.relays     = '0;
            st_next.last_fault = overheat ? fcps_pkg::FAULT_OVERHEAT
                                          : fcps_pkg::FAULT_LEAK;
          end else begin
            move_out = moved;
            if (ox_age_adv > fcps_pkg::OX_OPEN_MS) begin
              if (ox_age_adv > fcps_pkg::OX_CLOSE_MS) begin
                st_next.relays[fcps_pkg::B_OXP] = 1'b0;
                st_next.ox_purging = 1'b0;
                st_next.ox_age     = '0;
              end else if (!st.ox_purging) begin
                st_next.relays[fcps_pkg::B_OXP] = 1'b1;
                st_next.ox_purging = 1'b1;
              end
            end
            if (hy_age_adv > fcps_pkg::HY_OPEN_MS) begin
              if (hy_age_adv > fcps_pkg::HY_CLOSE_MS) begin
                st_next.relays[fcps_pkg::B_H2P] = 1'b0;
                st_next.hy_purging = 1'b0;
                st_next.hy_age     = '0;
              end else if (!st.hy_purging) begin
                st_next.relays[fcps_pkg::B_H2P] = 1'b1;
                st_next.hy_purging = 1'b1;
              end
            end
          end
        end
      end
      default: ; // unused opcode: hold all state
    endcase
  end

  assign res.main_pump           = st_next.relays[fcps_pkg::B_PUMP];
  assign res.sea_pump            = st_next.relays[fcps_pkg::B_SEA];
  assign res.heater_relay        = st_next.relays[fcps_pkg::B_HEATER];
  assign res.heater_bypass_valve = st_next.relays[fcps_pkg::B_HBYP];
  assign res.sea_bypass_valve    = st_next.relays[fcps_pkg::B_SBYP];
  assign res.air_compressor      = st_next.relays[fcps_pkg::B_AIR];
  assign res.oxygen_purge        = st_next.relays[fcps_pkg::B_OXP];
  assign res.hydrogen_feed       = st_next.relays[fcps_pkg::B_H2F];
  assign res.hydrogen_purge      = st_next.relays[fcps_pkg::B_H2P];
  assign res.running             = st_next.run_flag;
  assign res.fault_code          = st_next.last_fault;
  assign res.valve_move          = move_out;

endmodule

FILE: test/tb.sv
// Self-checking testbench for fuel_cell_plant_supervisor_core.
// Drives ticks and start/stop commands against a behavioral plant predictor.
// Depends on fcps_pkg and the supervisor RTL.
`timescale 1ns / 1ps

module tb;

  // Opcode the block must ignore; the package gives it no name.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned PHASES          = 7;
  localparam int unsigned SETTLE_CYCLES   = 4;     // two-stage pipe plus margin
  localparam int unsigned IDLE_LIMIT      = 2000;  // cycles with no transfer at all

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One line of the directed plan: an item (optionally with a hand-written
  // result) or a single register write.
  typedef struct packed {
    row_kind_t                           kind;
    fcps_pkg::item_t                     item;
    logic                                pinned;
    fcps_pkg::result_t                   pin_val;
    logic [fcps_pkg::CFG_INDEX_W-1:0]    reg_index;
    logic [fcps_pkg::CFG_DATA_W-1:0]     reg_value;
  } dir_row_t;

  typedef struct packed {
    logic              pinned;
    fcps_pkg::result_t val;
  } pin_t;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  fcps_pkg::item_t                  in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  fcps_pkg::result_t                out_data;
  logic                             cfg_we    = 1'b0;
  logic [fcps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fcps_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Idle mix: percent of cycles the sender holds off / the receiver stalls.
  int unsigned gap_pct   = 14;
  int unsigned stall_pct = 52;

  // Predicted plant: configuration and supervisor state.
  fcps_pkg::cfg_t               plant_cfg;
  logic                         plant_run;
  logic [6:0]                   plant_hot;
  logic [31:0]                  plant_clock;
  logic [31:0]                  ox_mark;
  logic [31:0]                  hy_mark;
  logic                         ox_purging;
  logic                         hy_purging;
  logic [fcps_pkg::RELAY_W-1:0] plant_relays;
  logic [1:0]                   plant_fault;

  pin_t              pin_q[$];       // per sent item, hand-written result if any
  fcps_pkg::result_t expected_q[$];  // results owed by the block, oldest first

  int unsigned error_count     = 0;
  int unsigned items_taken     = 0;
  int unsigned results_checked = 0;
  int unsigned configs_loaded  = 0;
  int unsigned overheat_trips  = 0;
  int unsigned leak_trips      = 0;
  int unsigned ox_purges       = 0;
  int unsigned hy_purges       = 0;
  int unsigned quiet_cycles    = 0;

  always #1 clk = ~clk;

  fuel_cell_plant_supervisor_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Plant predictor
  // ---------------------------------------------------------------------------

  function automatic fcps_pkg::cfg_t default_config();
    fcps_pkg::cfg_t c;
    c.heat_below     = 12'd280;
    c.warm_above     = 12'd288;
    c.hot_from       = 12'd320;
    c.cool_above     = 12'd328;
    c.overheat_temp  = 12'd360;
    c.overheat_ticks = 7'd100;
    c.leak_limit     = 10'd300;
    return c;
  endfunction

  // Clear the plant state; run is 0 at reset and 1 on a start command.
  function automatic void arm_plant(input logic run);
    plant_run    = run;
    plant_hot    = '0;
    plant_clock  = '0;
    ox_mark      = '0;
    hy_mark      = '0;
    ox_purging   = 1'b0;
    hy_purging   = 1'b0;
    plant_relays = '0;
    plant_fault  = fcps_pkg::FAULT_NONE;
  endfunction

  // Drop every relay, halt, and latch the fault code.
  function automatic void trip(input logic [1:0] code);
    plant_relays = '0;
    plant_run    = 1'b0;
    ox_purging   = 1'b0;
    hy_purging   = 1'b0;
    plant_fault  = code;
    if (code == fcps_pkg::FAULT_OVERHEAT) begin
      overheat_trips++;
    end else if (code == fcps_pkg::FAULT_LEAK) begin
      leak_trips++;
    end
  endfunction

  // Coolant pattern: main pump always on, sea branch valve always off.
  function automatic void coolant(input logic heater, input logic bypass, input logic sea);
    plant_relays[fcps_pkg::B_HEATER] = heater;
    plant_relays[fcps_pkg::B_HBYP]   = bypass;
    plant_relays[fcps_pkg::B_SBYP]   = 1'b0;
    plant_relays[fcps_pkg::B_PUMP]   = 1'b1;
    plant_relays[fcps_pkg::B_SEA]    = sea;
  endfunction

  // Advance the plant by one accepted item and return the result it owes.
  function automatic fcps_pkg::result_t supervise(input fcps_pkg::item_t it);
    fcps_pkg::result_t r;
    logic              moved;
    logic              halted;
    logic [31:0]       age;
    moved  = 1'b0;
    halted = 1'b0;
    case (it.opcode)
      fcps_pkg::OP_START: if (!plant_run) arm_plant(1'b1);
      fcps_pkg::OP_STOP: if (plant_run) trip(fcps_pkg::FAULT_STOP);
      fcps_pkg::OP_TICK: if (plant_run) begin
        plant_clock = plant_clock + {16'd0, it.elapsed_ms};
        // Temperature bands: heater, mid band with gas feeds, hot with sea cooling.
        if (it.temperature_q < plant_cfg.heat_below) begin
          coolant(1'b1, 1'b0, 1'b0);
          moved     = 1'b1;
          plant_hot = '0;
        end else if (it.temperature_q < plant_cfg.hot_from) begin
          if (it.temperature_q > plant_cfg.warm_above) begin
            coolant(1'b0, 1'b1, 1'b0);
            moved = 1'b1;
          end
          plant_relays[fcps_pkg::B_H2F] = 1'b1;
          plant_relays[fcps_pkg::B_AIR] = 1'b1;
          plant_hot                     = '0;
        end else if (it.temperature_q > plant_cfg.cool_above) begin
          coolant(1'b0, 1'b1, 1'b1);
          moved = 1'b1;
          if (plant_hot != fcps_pkg::HOT_MAX) plant_hot = plant_hot + 7'd1;
        end
        // Overheat outranks a leak; either one skips the purge logic.
        if (plant_hot >= plant_cfg.overheat_ticks &&
            it.temperature_q > plant_cfg.overheat_temp) begin
          trip(fcps_pkg::FAULT_OVERHEAT);
          halted = 1'b1;
        end else if (it.hydrogen_feed_level > plant_cfg.leak_limit ||
                     it.hydrogen_exhaust_level > plant_cfg.leak_limit) begin
          trip(fcps_pkg::FAULT_LEAK);
          halted = 1'b1;
        end else begin
          age = plant_clock - ox_mark;
          if (age > fcps_pkg::OX_OPEN_MS) begin
            if (!ox_purging) begin
              plant_relays[fcps_pkg::B_OXP] = 1'b1;
              ox_purging                    = 1'b1;
              ox_purges++;
            end
            if (age > fcps_pkg::OX_CLOSE_MS) begin
              plant_relays[fcps_pkg::B_OXP] = 1'b0;
              ox_purging                    = 1'b0;
              ox_mark                       = plant_clock;
            end
          end
          age = plant_clock - hy_mark;
          if (age > fcps_pkg::HY_OPEN_MS) begin
            if (!hy_purging) begin
              plant_relays[fcps_pkg::B_H2P] = 1'b1;
              hy_purging                    = 1'b1;
              hy_purges++;
            end
            if (age > fcps_pkg::HY_CLOSE_MS) begin
              plant_relays[fcps_pkg::B_H2P] = 1'b0;
              hy_purging                    = 1'b0;
              hy_mark                       = plant_clock;
            end
          end
        end
      end
      default: ;
    endcase
    r.main_pump           = plant_relays[fcps_pkg::B_PUMP];
    r.sea_pump            = plant_relays[fcps_pkg::B_SEA];
    r.heater_relay        = plant_relays[fcps_pkg::B_HEATER];
    r.heater_bypass_valve = plant_relays[fcps_pkg::B_HBYP];
    r.sea_bypass_valve    = plant_relays[fcps_pkg::B_SBYP];
    r.air_compressor      = plant_relays[fcps_pkg::B_AIR];
    r.oxygen_purge        = plant_relays[fcps_pkg::B_OXP];
    r.hydrogen_feed       = plant_relays[fcps_pkg::B_H2F];
    r.hydrogen_purge      = plant_relays[fcps_pkg::B_H2P];
    r.running             = plant_run;
    r.fault_code          = plant_fault;
    r.valve_move          = moved && !halted;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [1:0] want,
                                      input logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every input transfer, check every result transfer.
  // Everything is sampled at the rising edge, before the block's own updates.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    fcps_pkg::result_t want;
    pin_t              pn;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = supervise(in_data);
        pn   = pin_q.pop_front();
        // A hand-written result replaces the prediction for directed rows.
        if (pn.pinned) want = pn.val;
        expected_q.push_back(want);
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          error_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("main_pump", want.main_pump, out_data.main_pump);
          check_field("sea_pump", want.sea_pump, out_data.sea_pump);
          check_field("heater_relay", want.heater_relay, out_data.heater_relay);
          check_field("heater_bypass_valve", want.heater_bypass_valve,
                      out_data.heater_bypass_valve);
          check_field("sea_bypass_valve", want.sea_bypass_valve, out_data.sea_bypass_valve);
          check_field("air_compressor", want.air_compressor, out_data.air_compressor);
          check_field("oxygen_purge", want.oxygen_purge, out_data.oxygen_purge);
          check_field("hydrogen_feed", want.hydrogen_feed, out_data.hydrogen_feed);
          check_field("hydrogen_purge", want.hydrogen_purge, out_data.hydrogen_purge);
          check_field("running", want.running, out_data.running);
          check_field("fault_code", want.fault_code, out_data.fault_code);
          check_field("valve_move", want.valve_move, out_data.valve_move);
          results_checked++;
        end
      end
    end
  end

  // Receiver side: stall at random per the current idle mix.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one item, with random hold-off first; return once it is taken.
  task automatic send(input fcps_pkg::item_t it, input pin_t pn);
    pin_q.push_back(pn);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the input side until every owed result has come back, then let the
  // pipe go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0 || pin_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write.
  task automatic write_reg(input logic [fcps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [fcps_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      fcps_pkg::REG_HEAT_BELOW:     plant_cfg.heat_below     = value;
      fcps_pkg::REG_WARM_ABOVE:     plant_cfg.warm_above     = value;
      fcps_pkg::REG_HOT_FROM:       plant_cfg.hot_from       = value;
      fcps_pkg::REG_COOL_ABOVE:     plant_cfg.cool_above     = value;
      fcps_pkg::REG_OVERHEAT_TEMP:  plant_cfg.overheat_temp  = value;
      fcps_pkg::REG_OVERHEAT_TICKS: plant_cfg.overheat_ticks = value[6:0];
      fcps_pkg::REG_LEAK_LIMIT:     plant_cfg.leak_limit     = value[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(input fcps_pkg::cfg_t c);
    settle();
    write_reg(fcps_pkg::REG_HEAT_BELOW, c.heat_below);
    write_reg(fcps_pkg::REG_WARM_ABOVE, c.warm_above);
    write_reg(fcps_pkg::REG_HOT_FROM, c.hot_from);
    write_reg(fcps_pkg::REG_COOL_ABOVE, c.cool_above);
    write_reg(fcps_pkg::REG_OVERHEAT_TEMP, c.overheat_temp);
    write_reg(fcps_pkg::REG_OVERHEAT_TICKS, {5'd0, c.overheat_ticks});
    write_reg(fcps_pkg::REG_LEAK_LIMIT, {2'd0, c.leak_limit});
    cfg_we <= 1'b0;
    configs_loaded++;
  endtask

  // Mostly ordered thresholds so every band is reachable; sometimes scrambled.
  function automatic fcps_pkg::cfg_t random_config();
    fcps_pkg::cfg_t c;
    int unsigned    t;
    t = $urandom_range(0, 3700);
    c.heat_below = 12'(t);
    t = t + $urandom_range(0, 40);
    c.warm_above = 12'(t);
    t = t + $urandom_range(0, 80);
    c.hot_from = 12'(t);
    t = t + $urandom_range(0, 40);
    c.cool_above = 12'(t);
    t = t + $urandom_range(0, 80);
    c.overheat_temp = 12'(t);
    if ($urandom_range(0, 3) == 0) begin
      c.heat_below    = 12'($urandom_range(0, 4095));
      c.warm_above    = 12'($urandom_range(0, 4095));
      c.hot_from      = 12'($urandom_range(0, 4095));
      c.cool_above    = 12'($urandom_range(0, 4095));
      c.overheat_temp = 12'($urandom_range(0, 4095));
    end
    c.overheat_ticks = 7'($urandom_range(1, 24));
    c.leak_limit     = 10'($urandom_range(200, 1023));
    return c;
  endfunction

  // Favor temperatures on and next to the thresholds, and long hot runs.
  function automatic logic [11:0] pick_temperature();
    int          t;
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 2) begin
      t = int'($urandom_range(0, 4095));
    end else if (k < 7) begin
      case ($urandom_range(0, 4))
        0:       t = int'(plant_cfg.heat_below);
        1:       t = int'(plant_cfg.warm_above);
        2:       t = int'(plant_cfg.hot_from);
        3:       t = int'(plant_cfg.cool_above);
        default: t = int'(plant_cfg.overheat_temp);
      endcase
      t = t + int'($urandom_range(0, 2)) - 1;
    end else begin
      t = int'($urandom_range(32'(plant_cfg.cool_above), 4095));
    end
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return 12'(t);
  endfunction

  // Mostly safe readings; a few leaks.
  function automatic logic [9:0] pick_hydrogen();
    if ($urandom_range(0, 99) < 3) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(0, 32'(plant_cfg.leak_limit)));
  endfunction

  // Short steps mostly, so purge windows get crossed inside a run.
  function automatic logic [15:0] pick_elapsed();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 5) return 16'($urandom_range(0, 2000));
    if (k < 9) return 16'($urandom_range(2000, 20000));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Restart promptly after a halt so most ticks land on a running plant.
  function automatic fcps_pkg::item_t random_item();
    fcps_pkg::item_t it;
    int unsigned     k;
    k = $urandom_range(0, 99);
    if (!plant_run && k < 60) begin
      it.opcode = fcps_pkg::OP_START;
    end else if (k < 2) begin
      it.opcode = OP_UNUSED;
    end else if (k < 5) begin
      it.opcode = fcps_pkg::OP_STOP;
    end else if (k < 10) begin
      it.opcode = fcps_pkg::OP_START;
    end else begin
      it.opcode = fcps_pkg::OP_TICK;
    end
    it.temperature_q          = pick_temperature();
    it.hydrogen_feed_level    = pick_hydrogen();
    it.hydrogen_exhaust_level = pick_hydrogen();
    it.elapsed_ms             = pick_elapsed();
    return it;
  endfunction

  function automatic dir_row_t item_row(input logic [1:0] op, input logic [11:0] t,
                                        input logic [9:0] feed, input logic [9:0] exhaust,
                                        input logic [15:0] ms);
    dir_row_t r;
    r                             = '0;
    r.kind                        = ROW_ITEM;
    r.item.opcode                 = op;
    r.item.temperature_q          = t;
    r.item.hydrogen_feed_level    = feed;
    r.item.hydrogen_exhaust_level = exhaust;
    r.item.elapsed_ms             = ms;
    return r;
  endfunction

  function automatic dir_row_t pin_row(input dir_row_t r, input fcps_pkg::result_t want);
    r.pinned  = 1'b1;
    r.pin_val = want;
    return r;
  endfunction

  // All relays off, valve pulse low: the result of a start from halt, a stop and a fault.
  function automatic fcps_pkg::result_t quiet_result(input logic run, input logic [1:0] fault);
    fcps_pkg::result_t r;
    r            = '0;
    r.running    = run;
    r.fault_code = fault;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t          plan[$];
    dir_row_t          r;
    fcps_pkg::result_t heater_on;
    pin_t              pn;
    fcps_pkg::item_t   it;
    fcps_pkg::cfg_t    c;
    int unsigned       counted;
    int unsigned       hold_at;
    logic              held;

    plant_cfg = default_config();
    arm_plant(1'b0);

    heater_on              = quiet_result(1'b1, fcps_pkg::FAULT_NONE);
    heater_on.main_pump    = 1'b1;
    heater_on.heater_relay = 1'b1;
    heater_on.valve_move   = 1'b1;

    // Commands before any start, the ignored opcode, then start twice.
    plan.push_back(pin_row(item_row(fcps_pkg::OP_TICK, 12'd300, 10'd0, 10'd0, 16'd100),
                           quiet_result(1'b0, fcps_pkg::FAULT_NONE)));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_STOP, 12'd0, 10'd0, 10'd0, 16'd0),
                           quiet_result(1'b0, fcps_pkg::FAULT_NONE)));
    plan.push_back(pin_row(item_row(OP_UNUSED, 12'd4095, 10'd1023, 10'd1023, 16'd65535),
                           quiet_result(1'b0, fcps_pkg::FAULT_NONE)));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_START, 12'd0, 10'd0, 10'd0, 16'd0),
                           quiet_result(1'b1, fcps_pkg::FAULT_NONE)));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_START, 12'd4095, 10'd0, 10'd0, 16'd0),
                           quiet_result(1'b1, fcps_pkg::FAULT_NONE)));
    // Walk the band edges at reset thresholds; large steps open the hydrogen purge and pass both close marks.
    plan.push_back(pin_row(item_row(fcps_pkg::OP_TICK, 12'd0, 10'd0, 10'd0, 16'd0),
                           heater_on));
    plan.push_back(item_row(fcps_pkg::OP_TICK, 12'd280, 10'd0, 10'd0, 16'd1000));
    plan.push_back(item_row(fcps_pkg::OP_TICK, 12'd288, 10'd0, 10'd0, 16'd0));
    plan.push_back(item_row(fcps_pkg::OP_TICK, 12'd289, 10'd0, 10'd0, 16'd0));
    plan.push_back(item_row(fcps_pkg::OP_TICK, 12'd319, 10'd0, 10'd0, 16'd0));
    plan.push_back(item_row(fcps_pkg::OP_TICK, 12'd320, 10'd0, 10'd0, 16'd0));
    plan.push_back(item_row(fcps_pkg::OP_TICK, 12'd328, 10'd0, 10'd0, 16'd0));
    plan.push_back(item_row(fcps_pkg::OP_TICK, 12'd329, 10'd0, 10'd0, 16'd61000));
    plan.push_back(item_row(fcps_pkg::OP_TICK, 12'd4095, 10'd300, 10'd300, 16'd3000));
    plan.push_back(item_row(fcps_pkg::OP_TICK, 12'd279, 10'd0, 10'd0, 16'd65535));
    plan.push_back(item_row(fcps_pkg::OP_TICK, 12'd100, 10'd0, 10'd0, 16'd65535));
    // Leak on each sensor; a held fault survives ticks and stop, start clears it.
    plan.push_back(pin_row(item_row(fcps_pkg::OP_TICK, 12'd300, 10'd1023, 10'd0, 16'd5),
                           quiet_result(1'b0, fcps_pkg::FAULT_LEAK)));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_TICK, 12'd300, 10'd0, 10'd0, 16'd5),
                           quiet_result(1'b0, fcps_pkg::FAULT_LEAK)));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_STOP, 12'd0, 10'd0, 10'd0, 16'd0),
                           quiet_result(1'b0, fcps_pkg::FAULT_LEAK)));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_START, 12'd0, 10'd0, 10'd0, 16'd0),
                           quiet_result(1'b1, fcps_pkg::FAULT_NONE)));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_TICK, 12'd300, 10'd0, 10'd301, 16'd0),
                           quiet_result(1'b0, fcps_pkg::FAULT_LEAK)));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_START, 12'd0, 10'd0, 10'd0, 16'd0),
                           quiet_result(1'b1, fcps_pkg::FAULT_NONE)));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_STOP, 12'd0, 10'd0, 10'd0, 16'd0),
                           quiet_result(1'b0, fcps_pkg::FAULT_STOP)));
    // One hot tick is enough from here: overheat at its edge, and over a leak.
    r           = '0;
    r.kind      = ROW_REG;
    r.reg_index = fcps_pkg::REG_OVERHEAT_TICKS;
    r.reg_value = 12'd1;
    plan.push_back(r);
    plan.push_back(pin_row(item_row(fcps_pkg::OP_START, 12'd0, 10'd0, 10'd0, 16'd0),
                           quiet_result(1'b1, fcps_pkg::FAULT_NONE)));
    plan.push_back(item_row(fcps_pkg::OP_TICK, 12'd360, 10'd0, 10'd0, 16'd0));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_TICK, 12'd4095, 10'd1023, 10'd1023, 16'd0),
                           quiet_result(1'b0, fcps_pkg::FAULT_OVERHEAT)));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_START, 12'd0, 10'd0, 10'd0, 16'd0),
                           quiet_result(1'b1, fcps_pkg::FAULT_NONE)));
    plan.push_back(pin_row(item_row(fcps_pkg::OP_TICK, 12'd361, 10'd0, 10'd0, 16'd0),
                           quiet_result(1'b0, fcps_pkg::FAULT_OVERHEAT)));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].reg_index, plan[i].reg_value);
        cfg_we <= 1'b0;
      end else begin
        pn.pinned = plan[i].pinned;
        pn.val    = plan[i].pin_val;
        send(plan[i].item, pn);
      end
    end

    // Random phases, one register setting each; idle mix changes partway.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        gap_pct   = 52;
        stall_pct = 14;
      end
      if (p == 5) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      case (p)
        0: c = default_config();
        1: begin
          c                = '0;
          c.overheat_ticks = 7'd1;
        end
        2: c = '1;
        3: begin
          // Hot counting that can never trip: saturation of the counter.
          c.heat_below     = 12'd100;
          c.warm_above     = 12'd200;
          c.hot_from       = 12'd300;
          c.cool_above     = 12'd400;
          c.overheat_temp  = 12'd4095;
          c.overheat_ticks = 7'd127;
          c.leak_limit     = 10'd1023;
        end
        default: c = random_config();
      endcase
      load_config(c);
      hold_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
      held    = 1'b0;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = random_item();
        // Unused opcodes, and ticks and stops on a halted plant, do not count toward the phase.
        if (it.opcode != OP_UNUSED && (plant_run || it.opcode == fcps_pkg::OP_START)) begin
          counted++;
        end
        send(it, '0);
        if (!held && counted >= hold_at) begin
          held = 1'b1;
          settle();
        end
      end
    end

    settle();

    $display("covered %0d items, %0d results checked, %0d register settings, three idle mixes",
             items_taken, results_checked, configs_loaded);
    $display("trips: %0d overheat, %0d leak; purges opened: %0d oxygen, %0d hydrogen",
             overheat_trips, leak_trips, ox_purges, hy_purges);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/fcps_pkg.sv
hdl/fcps_cfg_regs.sv
hdl/fcps_step.sv
hdl/fuel_cell_plant_supervisor_core.sv
test/tb.sv
